// File: design/skvt_pkg.sv
// shared constants and types for the sorted key/value table
// no dependencies; used by skvt_ctrl and sorted_key_value_table_unit
package skvt_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int ENTRY_W  = 7;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [VAL_W-1:0] value;
		logic             status;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

// File: design/skvt_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module skvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/skvt_ctrl.sv
// search and insert sequencer: binary search over the entry ram, overwrite,
// and shift-up insert one entry per cycle; uses skvt_pkg
module skvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [31:0]         key,
	input  logic [31:0]         value_in,
	output skvt_pkg::mem_req_t  mem,
	input  skvt_pkg::entry_t    rd_data,
	output skvt_pkg::result_t   res,
	input  logic                res_take
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SRCH  = 6'b000010,
		ST_SCMP  = 6'b000100,
		ST_CHK   = 6'b001000,
		ST_SHIFT = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	localparam logic [skvt_pkg::CNT_W-1:0] CAP_CNT = skvt_pkg::CNT_W'(skvt_pkg::CAPACITY);

	state_t                             state_q;
	logic [skvt_pkg::CNT_W-1:0]         count_q;
	logic [skvt_pkg::CNT_W-1:0]         lo_q, hi_q, mid_q, dst_q;
	logic [skvt_pkg::CNT_W-1:0]         mid;
	logic                               cmd_q;
	logic [skvt_pkg::KEY_W-1:0]         key_q;
	logic [skvt_pkg::VAL_W-1:0]         val_q;
	logic                               found_q, status_q;
	logic [skvt_pkg::VAL_W-1:0]         vout_q;
	logic                               pend_s1;
	logic [skvt_pkg::ADDR_W-1:0]        pend_addr_s1;
	logic                               hit;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign hit      = (rd_data.key == key_q);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		mem       = '0;
		mem.wdata = '{key: key_q, value: val_q};
		unique case (state_q)
			ST_SRCH: begin
				mem.raddr = (lo_q < hi_q) ? mid[skvt_pkg::ADDR_W-1:0]
				                          : lo_q[skvt_pkg::ADDR_W-1:0];
			end
			ST_CHK: begin
				mem.we    = hit && (cmd_q == skvt_pkg::CMD_SET);
				mem.waddr = lo_q[skvt_pkg::ADDR_W-1:0];
			end
			ST_SHIFT: begin
				// move the entry read last cycle up by one, then drop in the new pair
				if (pend_s1) begin
					mem.we    = 1'b1;
					mem.waddr = pend_addr_s1;
					mem.wdata = rd_data;
				end else if (dst_q == lo_q) begin
					mem.we    = 1'b1;
					mem.waddr = lo_q[skvt_pkg::ADDR_W-1:0];
				end
				mem.raddr = dst_q[skvt_pkg::ADDR_W-1:0] - 1'b1;
			end
			ST_IDLE, ST_SCMP, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= ST_SCMP;
					end else if (lo_q < count_q) begin
						state_q <= ST_CHK;
					end else if (cmd_q == skvt_pkg::CMD_SET && count_q != CAP_CNT) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SCMP: begin
					state_q <= ST_SRCH;
				end
				ST_CHK: begin
					if (!hit && cmd_q == skvt_pkg::CMD_SET && count_q != CAP_CNT) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					pend_s1 <= (dst_q > lo_q);
					if (!pend_s1 && dst_q == lo_q) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= dst_q[skvt_pkg::ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd_q    <= cmd;
				key_q    <= key;
				val_q    <= value_in;
				lo_q     <= '0;
				hi_q     <= count_q;
				found_q  <= 1'b0;
				vout_q   <= '0;
				status_q <= skvt_pkg::STATUS_OK;
			end
			ST_SRCH: begin
				mid_q <= mid;
				dst_q <= count_q;
				if (lo_q >= hi_q && lo_q >= count_q && cmd_q == skvt_pkg::CMD_SET
				    && count_q == CAP_CNT) begin
					status_q <= skvt_pkg::STATUS_FULL;
				end
			end
			ST_SCMP: begin
				if (rd_data.key < key_q) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_CHK: begin
				if (hit) begin
					found_q <= 1'b1;
					vout_q  <= rd_data.value;
				end else if (cmd_q == skvt_pkg::CMD_SET && count_q == CAP_CNT) begin
					status_q <= skvt_pkg::STATUS_FULL;
				end
			end
			ST_SHIFT: begin
				if (dst_q > lo_q) begin
					dst_q <= dst_q - 1'b1;
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.valid  = (state_q == ST_RESP);
		res.found  = found_q;
		res.value  = vout_q;
		res.status = status_q;
		res.count  = count_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
		else $error("entry count moved by more than one");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH || state_q == ST_SCMP) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("binary search bounds crossed");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem.we |-> (state_q == ST_CHK || state_q == ST_SHIFT))
		else $error("ram write outside overwrite or insert");

	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.found && res.status == skvt_pkg::STATUS_FULL))
		else $error("hit reported together with full refusal");

endmodule

// File: design/sorted_key_value_table_unit.sv
// Sorted key/value table, up to skvt_pkg::CAPACITY entries in ascending key order.
// Input channel (in_valid/in_ready): cmd, key, value_in. cmd get looks a key up,
// cmd set overwrites a present key or inserts a new one in sorted position.
// Output channel (out_valid/out_ready): found, value_out (stored or replaced
// value on a hit, else 0), status (1 when an insert is refused as the table is
// full) and entry_count after the transaction. One result per transaction.
// The binary search takes a read state and a compare state per halving step
// over one registered-read ram port, then a check state when it stops inside
// the stored entries; the result then passes through the output register. An
// insert then shifts the entries above the insert point up one per cycle before
// writing the new pair; no entries move when the key goes in at the end.
// One transaction is processed at a time; the next is accepted as soon
// as the previous result sits in the output register.
// Reset clears the entry count; ram contents are never read above the count,
// so no clearing pass is needed. When the receiver stalls, the result is held
// in the output register and the sequencer waits with its own result pending.
// uses skvt_pkg, skvt_ram, skvt_ctrl
module sorted_key_value_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] key,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] value_out,
	output logic        status,
	output logic [6:0]  entry_count
);

	skvt_pkg::mem_req_t mem;
	skvt_pkg::entry_t   rd_data;
	skvt_pkg::result_t  res;
	logic               res_take;
	logic               out_valid_q;

	skvt_ram #(
		.WIDTH($bits(skvt_pkg::entry_t)),
		.DEPTH(skvt_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wdata),
		.raddr(mem.raddr),
		.rdata(rd_data)
	);

	skvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.key     (key),
		.value_in(value_in),
		.mem     (mem),
		.rd_data (rd_data),
		.res     (res),
		.res_take(res_take)
	);

	// output register frees the sequencer while the receiver stalls
	assign res_take = res.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			found       <= res.found;
			value_out   <= res.value;
			status      <= res.status;
			entry_count <= skvt_pkg::ENTRY_W'(res.count);
		end
	end

	assign out_valid = out_valid_q;

endmodule
